FILE: hw/rtl/iirrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirrs_pkg
// Shared widths, register codes, sequencer states and saturation helpers for
// the iir oversampling resampler.
// ----------------------------------------------------------------------------
package iirrs_pkg;

  localparam int SECTIONS_DEF   = 2;
  localparam int MAX_FACTOR_DEF = 16;

  localparam int SAMPLE_W   = 24;  // Q1.23 audio
  localparam int UP_X_W     = 28;  // sample times factor
  localparam int Y_W        = 56;  // Q32.24 section state
  localparam int YL_W       = 24;  // low slice of a state word
  localparam int COEF_W     = 32;
  localparam int FACTOR_W   = 5;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = 64;
  localparam int MUL_W      = 33;  // signed operand width of the shared multiplier
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 90;

  localparam int FB_SHIFT   = 30;  // Q2.30 feedback coefficients
  localparam int GAIN_SHIFT = 33;  // Q0.32 gain and Q.24 to Q.23

  localparam logic signed [ACC_W-1:0] RND_FB   = ACC_W'(1) << (FB_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] RND_GAIN = ACC_W'(1) << (GAIN_SHIFT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_FACTOR = 3'd0,
    REG_OUTPUT_GAIN = 3'd1,
    REG_S1_A1       = 3'd2,
    REG_S1_A2       = 3'd3,
    REG_S2_A1       = 3'd4,
    REG_S2_A2       = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACC,
    ST_ADD,
    ST_SAT,
    ST_OUT
  } state_t;

  function automatic logic signed [Y_W-1:0] sat_y(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = (SUM_W'(1) <<< (Y_W - 1)) - SUM_W'(1);
    lo = -(SUM_W'(1) <<< (Y_W - 1));
    priority if (v > hi) begin
      sat_y = {1'b0, {(Y_W - 1){1'b1}}};
    end else if (v < lo) begin
      sat_y = {1'b1, {(Y_W - 1){1'b0}}};
    end else begin
      sat_y = v[Y_W-1:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = (SUM_W'(1) <<< (SAMPLE_W - 1)) - SUM_W'(1);
    lo = -(SUM_W'(1) <<< (SAMPLE_W - 1));
    priority if (v > hi) begin
      sat_sample = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (v < lo) begin
      sat_sample = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      sat_sample = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/iir_oversampling_resampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iir_oversampling_resampler
// Integer-factor resampler on a cascade of second-order low-pass sections with
// a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// One shared 33x33 signed multiplier computes every feedback product and the
// output gain, each as two partial products (high product, low product,
// accumulate, round and add). One filter run passes through every section,
// followed by the gain product and output load when it yields a result; an
// up-mode transaction repeats the run for each of its factor results, and a
// down-mode transaction yields a result only when its decimation count
// completes. in_stall stays high for the whole run; a finished result sits
// in the output register and the block accepts the next transaction while
// it waits there. Up and down filters keep separate state. Configuration is
// written through cfg_valid/cfg_ready while the sequencer is idle; unknown
// register indexes are dropped.
module iir_oversampling_resampler #(
  parameter int SECTIONS   = iirrs_pkg::SECTIONS_DEF,
  parameter int MAX_FACTOR = iirrs_pkg::MAX_FACTOR_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic signed [iirrs_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [iirrs_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                   out_last,
  output logic                                   out_from_down,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iirrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iirrs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import iirrs_pkg::*;

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int K_W   = $clog2(MAX_FACTOR);
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);

  // configuration
  logic [FACTOR_W-1:0]      rate_factor_r, rate_factor_nxt;
  logic [COEF_W-1:0]        output_gain_r, output_gain_nxt;
  logic signed [COEF_W-1:0] s1_a1_r, s1_a1_nxt, s1_a2_r, s1_a2_nxt;
  logic signed [COEF_W-1:0] s2_a1_r, s2_a1_nxt, s2_a2_r, s2_a2_nxt;

  // filter state, bank 0 up, bank 1 down
  logic signed [UP_X_W-1:0]   up_h1_r, up_h1_nxt, up_h2_r, up_h2_nxt;
  logic signed [SAMPLE_W-1:0] dn_h1_r, dn_h1_nxt, dn_h2_r, dn_h2_nxt;
  logic signed [Y_W-1:0]      o1_r   [2][SECTIONS];
  logic signed [Y_W-1:0]      o1_nxt [2][SECTIONS];
  logic signed [Y_W-1:0]      o2_r   [2][SECTIONS];
  logic signed [Y_W-1:0]      o2_nxt [2][SECTIONS];
  logic [PHASE_W-1:0]         phase_r, phase_nxt;

  // sequencer
  state_t             state_r, state_nxt;
  logic               bank_r, bank_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic               term_r, term_nxt;
  logic               gain_r, gain_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [FACTOR_W-1:0] f_r, f_nxt;

  // datapath
  logic signed [UP_X_W-1:0] x_r, x_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [Y_W-1:0]    y_r, y_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_from_down_r, out_from_down_nxt;

  // combinational helpers
  logic [FACTOR_W-1:0]       f_eff;
  logic signed [29:0]        xf;
  logic [SEC_W-1:0]          rd_sec;
  logic signed [Y_W-1:0]     o1_rd, o2_rd;
  logic signed [UP_X_W-1:0]  h1_sel, h2_sel;
  logic signed [Y_W-1:0]     mac_y;
  logic signed [COEF_W-1:0]  coef_sel;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [SUM_W-1:0]   init_first, init_next;
  logic signed [Y_W-1:0]     y_sat;
  logic                      k_last;
  logic                      sec_last;

  always_comb begin
    priority if (rate_factor_r == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (rate_factor_r > FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = rate_factor_r;
    end
  end

  assign xf = $signed(in_sample) * $signed({1'b0, f_eff});

  // section init of a later stage reads the previous stage's history
  assign rd_sec = (state_r == ST_INIT && sec_r != '0) ? sec_r - SEC_W'(1) : sec_r;
  assign o1_rd  = o1_r[bank_r][rd_sec];
  assign o2_rd  = o2_r[bank_r][rd_sec];
  assign h1_sel = bank_r ? UP_X_W'(dn_h1_r) : up_h1_r;
  assign h2_sel = bank_r ? UP_X_W'(dn_h2_r) : up_h2_r;

  assign init_first = (SUM_W'(x_r) + (SUM_W'(h1_sel) <<< 1) + SUM_W'(h2_sel)) <<< 1;
  assign init_next  = SUM_W'(y_r) + (SUM_W'(o1_rd) <<< 1) + SUM_W'(o2_rd);

  always_comb begin
    priority if (gain_r) begin
      mac_y = y_r;
    end else if (!term_r) begin
      mac_y = o1_rd;
    end else begin
      mac_y = o2_rd;
    end
  end

  always_comb begin
    unique case ({sec_r[0], term_r})
      2'b00:   coef_sel = s1_a1_r;
      2'b01:   coef_sel = s1_a2_r;
      2'b10:   coef_sel = s2_a1_r;
      default: coef_sel = s2_a2_r;
    endcase
  end

  assign mul_a = gain_r ? $signed({1'b0, output_gain_r}) : MUL_W'(coef_sel);
  assign mul_b = (state_r == ST_MUL_HI) ? MUL_W'($signed(mac_y[Y_W-1:YL_W]))
                                        : $signed({{(MUL_W - YL_W){1'b0}}, mac_y[YL_W-1:0]});
  assign mul_p = mul_a * mul_b;

  assign acc_sh   = gain_r ? (acc_r >>> GAIN_SHIFT) : (acc_r >>> FB_SHIFT);
  assign y_sat    = sat_y(sum_r);
  assign k_last   = (FACTOR_W'(k_r) + FACTOR_W'(1)) == f_r;
  assign sec_last = sec_r == LAST_SEC;

  always_comb begin
    rate_factor_nxt   = rate_factor_r;
    output_gain_nxt   = output_gain_r;
    s1_a1_nxt         = s1_a1_r;
    s1_a2_nxt         = s1_a2_r;
    s2_a1_nxt         = s2_a1_r;
    s2_a2_nxt         = s2_a2_r;
    up_h1_nxt         = up_h1_r;
    up_h2_nxt         = up_h2_r;
    dn_h1_nxt         = dn_h1_r;
    dn_h2_nxt         = dn_h2_r;
    o1_nxt            = o1_r;
    o2_nxt            = o2_r;
    phase_nxt         = phase_r;
    state_nxt         = state_r;
    bank_nxt          = bank_r;
    sec_nxt           = sec_r;
    term_nxt          = term_r;
    gain_nxt          = gain_r;
    k_nxt             = k_r;
    f_nxt             = f_r;
    x_nxt             = x_r;
    sum_nxt           = sum_r;
    prod_nxt          = prod_r;
    acc_nxt           = acc_r;
    y_nxt             = y_r;
    out_valid_nxt     = out_valid_r;
    out_sample_nxt    = out_sample_r;
    out_last_nxt      = out_last_r;
    out_from_down_nxt = out_from_down_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RATE_FACTOR: rate_factor_nxt = cfg_data[FACTOR_W-1:0];
        REG_OUTPUT_GAIN: output_gain_nxt = cfg_data;
        REG_S1_A1:       s1_a1_nxt       = cfg_data;
        REG_S1_A2:       s1_a2_nxt       = cfg_data;
        REG_S2_A1:       s2_a1_nxt       = cfg_data;
        REG_S2_A2:       s2_a2_nxt       = cfg_data;
        default:         ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bank_nxt  = in_mode;
          x_nxt     = in_mode ? UP_X_W'(in_sample) : xf[UP_X_W-1:0];
          f_nxt     = f_eff;
          k_nxt     = '0;
          sec_nxt   = '0;
          gain_nxt  = 1'b0;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        term_nxt = 1'b0;
        if (sec_r == '0) begin
          sum_nxt = init_first;
        end else begin
          sum_nxt = init_next;
          // previous stage history moves once its old values are used
          o2_nxt[bank_r][rd_sec] = o1_rd;
          o1_nxt[bank_r][rd_sec] = y_r;
        end
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        prod_nxt  = mul_p;
        acc_nxt   = (ACC_W'(prod_r) <<< YL_W) + (gain_r ? RND_GAIN : RND_FB);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        sum_nxt = sum_r + $signed(acc_sh[SUM_W-1:0]);
        priority if (gain_r) begin
          state_nxt = ST_OUT;
        end else if (!term_r) begin
          term_nxt  = 1'b1;
          state_nxt = ST_MUL_HI;
        end else begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        y_nxt = y_sat;
        if (sec_last) begin
          o2_nxt[bank_r][sec_r] = o1_rd;
          o1_nxt[bank_r][sec_r] = y_sat;
          if (bank_r) begin
            dn_h2_nxt = dn_h1_r;
            dn_h1_nxt = x_r[SAMPLE_W-1:0];
          end else begin
            up_h2_nxt = up_h1_r;
            up_h1_nxt = x_r;
          end
          if (bank_r && ((FACTOR_W'(phase_r) + FACTOR_W'(1)) < f_r)) begin
            phase_nxt = phase_r + PHASE_W'(1);
            state_nxt = ST_IDLE;
          end else begin
            if (bank_r) begin
              phase_nxt = '0;
            end
            gain_nxt  = 1'b1;
            sum_nxt   = '0;
            state_nxt = ST_MUL_HI;
          end
        end else begin
          sec_nxt   = sec_r + SEC_W'(1);
          state_nxt = ST_INIT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_sample_nxt    = sat_sample(sum_r);
          out_last_nxt      = bank_r || k_last;
          out_from_down_nxt = bank_r;
          if (!bank_r && !k_last) begin
            // zero stuffing for the rest of the up run
            k_nxt     = k_r + K_W'(1);
            x_nxt     = '0;
            sec_nxt   = '0;
            gain_nxt  = 1'b0;
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      rate_factor_r <= FACTOR_W'(2);
      output_gain_r <= '0;
      s1_a1_r       <= '0;
      s1_a2_r       <= '0;
      s2_a1_r       <= '0;
      s2_a2_r       <= '0;
      up_h1_r       <= '0;
      up_h2_r       <= '0;
      dn_h1_r       <= '0;
      dn_h2_r       <= '0;
      phase_r       <= '0;
      bank_r        <= 1'b0;
      sec_r         <= '0;
      term_r        <= 1'b0;
      gain_r        <= 1'b0;
      k_r           <= '0;
      f_r           <= FACTOR_W'(1);
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < SECTIONS; i++) begin
          o1_r[b][i] <= '0;
          o2_r[b][i] <= '0;
        end
      end
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      rate_factor_r <= rate_factor_nxt;
      output_gain_r <= output_gain_nxt;
      s1_a1_r       <= s1_a1_nxt;
      s1_a2_r       <= s1_a2_nxt;
      s2_a1_r       <= s2_a1_nxt;
      s2_a2_r       <= s2_a2_nxt;
      up_h1_r       <= up_h1_nxt;
      up_h2_r       <= up_h2_nxt;
      dn_h1_r       <= dn_h1_nxt;
      dn_h2_r       <= dn_h2_nxt;
      phase_r       <= phase_nxt;
      bank_r        <= bank_nxt;
      sec_r         <= sec_nxt;
      term_r        <= term_nxt;
      gain_r        <= gain_nxt;
      k_r           <= k_nxt;
      f_r           <= f_nxt;
      o1_r          <= o1_nxt;
      o2_r          <= o2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r             <= x_nxt;
    sum_r           <= sum_nxt;
    prod_r          <= prod_nxt;
    acc_r           <= acc_nxt;
    y_r             <= y_nxt;
    out_sample_r    <= out_sample_nxt;
    out_last_r      <= out_last_nxt;
    out_from_down_r <= out_from_down_nxt;
  end

  assign in_stall      = state_r != ST_IDLE;
  assign cfg_ready     = state_r == ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_last      = out_last_r;
  assign out_from_down = out_from_down_r;

endmodule
`default_nettype wire

FILE: hw/rtl/iirrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirrs_checker
// Port-level checks for the iir oversampling resampler, bound to the top.
// ----------------------------------------------------------------------------
module iirrs_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [iirrs_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                  out_last,
  input  logic                                  out_from_down
);
  import iirrs_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample)
      && $stable(out_last) && $stable(out_from_down))
    else $error("result changed while stalled");

  // an accepted transaction keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // down results are always single and marked last
  a_down_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_from_down |-> out_last)
    else $error("down result without last");

  // a pending mid-run up result means the rest of its run is still in progress
  a_up_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input open before up run finished");

endmodule

bind iir_oversampling_resampler iirrs_checker u_iirrs_checker (.*);
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the iir oversampling resampler. A queue-fed driver
// offers samples with random gaps and a monitor stalls results at random,
// while a bit-accurate model of both filter paths predicts every output.
// ----------------------------------------------------------------------------
module tb_top;
  import iirrs_pkg::*;

  localparam int NSEC        = SECTIONS_DEF;
  localparam int FMAX        = MAX_FACTOR_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYC  = 60;
  localparam int LONG_HOLD   = 150;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 26;

  localparam logic MODE_UP   = 1'b0;
  localparam logic MODE_DOWN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  localparam int UP_PATH   = 0;
  localparam int DOWN_PATH = 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  typedef logic signed [127:0]   wide_t;
  typedef logic signed [Y_W-1:0] state_word_t;

  typedef struct packed {
    logic                       md;
    logic signed [SAMPLE_W-1:0] smp;
    logic [2:0]                 gap;
    logic                       drain;
  } feed_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       from_down;
  } resampled_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       in_mode   = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       out_from_down;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data  = '0;

  always #1 clk = ~clk;

  iir_oversampling_resampler i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_last      (out_last),
    .out_from_down (out_from_down),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // register shadows and filter state, both paths
  logic [FACTOR_W-1:0]      factor_sh = 5'd2;
  logic [31:0]              gain_sh   = '0;
  logic signed [COEF_W-1:0] fb_a1 [2] = '{default: '0};
  logic signed [COEF_W-1:0] fb_a2 [2] = '{default: '0};
  logic signed [UP_X_W-1:0] x_hist1 [2] = '{default: '0};
  logic signed [UP_X_W-1:0] x_hist2 [2] = '{default: '0};
  state_word_t              y_hist1 [2][NSEC] = '{default: '0};
  state_word_t              y_hist2 [2][NSEC] = '{default: '0};
  logic [PHASE_W-1:0]       decim_phase = '0;

  feed_item_t  sample_feed [$];
  resampled_t  resampled_q [$];

  feed_item_t  feed_cur;
  logic        feed_held     = 1'b0;
  int unsigned feed_gap      = 0;
  int unsigned issued_cnt    = 0;
  int unsigned taken_cnt     = 0;
  int unsigned results_taken = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_gen      = 0;

  // floor((a*b + 2^(s-1)) / 2^s)
  function automatic wide_t mul_round(input wide_t a, input wide_t b, input int s);
    return (a * b + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic wide_t clamp_to(input wide_t v, input int w);
    wide_t hi;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic state_word_t biquad_cascade(input int p, input wide_t x);
    wide_t       acc;
    state_word_t y [NSEC];
    int          i;
    for (i = 0; i < NSEC; i++) begin
      if (i == 0) begin
        acc = (x + 2 * wide_t'(x_hist1[p]) + wide_t'(x_hist2[p])) * 2;
      end else begin
        acc = wide_t'(y[i-1]) + 2 * wide_t'(y_hist1[p][i-1]) + wide_t'(y_hist2[p][i-1]);
      end
      acc = acc + mul_round(wide_t'(y_hist1[p][i]), wide_t'(fb_a1[i % 2]), FB_SHIFT)
                + mul_round(wide_t'(y_hist2[p][i]), wide_t'(fb_a2[i % 2]), FB_SHIFT);
      y[i] = state_word_t'(clamp_to(acc, Y_W));
    end
    for (i = 0; i < NSEC; i++) begin
      y_hist2[p][i] = y_hist1[p][i];
      y_hist1[p][i] = y[i];
    end
    x_hist2[p] = x_hist1[p];
    x_hist1[p] = UP_X_W'(x);
    return y[NSEC-1];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] apply_gain(input state_word_t y);
    return SAMPLE_W'(clamp_to(mul_round(wide_t'(y), wide_t'(gain_sh), GAIN_SHIFT),
                              SAMPLE_W));
  endfunction

  function automatic void resample_predict(input logic md,
                                           input logic signed [SAMPLE_W-1:0] smp);
    int          f;
    int          k;
    state_word_t y;
    resampled_t  r;
    f = int'(factor_sh);
    if (f == 0) f = 1;
    if (f > FMAX) f = FMAX;
    if (md == MODE_UP) begin
      for (k = 0; k < f; k++) begin
        y = biquad_cascade(UP_PATH, (k == 0) ? wide_t'(smp) * f : wide_t'(0));
        r.smp       = apply_gain(y);
        r.last      = (k == f - 1);
        r.from_down = 1'b0;
        resampled_q.push_back(r);
      end
    end else begin
      y = biquad_cascade(DOWN_PATH, wide_t'(smp));
      // a lowered factor can leave the count past its end: emit right away
      if (int'(decim_phase) + 1 >= f) begin
        decim_phase = '0;
        r.smp       = apply_gain(y);
        r.last      = 1'b1;
        r.from_down = 1'b1;
        resampled_q.push_back(r);
      end else begin
        decim_phase = decim_phase + 1'b1;
      end
    end
  endfunction

  // transactions on all three channels, checking and watchdog
  always @(posedge clk) begin
    logic       hit;
    resampled_t r;
    if (rst_n) begin
      hit = 1'b0;
      if (cfg_valid && cfg_ready) begin
        hit = 1'b1;
        case (cfg_index)
          REG_RATE_FACTOR: factor_sh = cfg_data[FACTOR_W-1:0];
          REG_OUTPUT_GAIN: gain_sh   = cfg_data;
          REG_S1_A1:       fb_a1[0]  = cfg_data;
          REG_S1_A2:       fb_a2[0]  = cfg_data;
          REG_S2_A1:       fb_a1[1]  = cfg_data;
          REG_S2_A2:       fb_a2[1]  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        hit = 1'b1;
        taken_cnt++;
        resample_predict(in_mode, in_sample);
      end
      if (out_valid && !out_stall) begin
        hit = 1'b1;
        results_taken++;
        if (resampled_q.size() == 0) begin
          $error("unexpected result: out_sample %0d", out_sample);
          mismatches++;
        end else begin
          r = resampled_q.pop_front();
          if (out_sample !== r.smp) begin
            $error("out_sample: expected %0d, got %0d", $signed(r.smp), out_sample);
            mismatches++;
          end
          if (out_last !== r.last) begin
            $error("last: expected %0d, got %0d", r.last, out_last);
            mismatches++;
          end
          if (out_from_down !== r.from_down) begin
            $error("from_down: expected %0d, got %0d", r.from_down, out_from_down);
            mismatches++;
          end
        end
      end
      if (hit) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("iir_oversampling_resampler: mismatch");
          $finish;
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    logic offer;
    offer = (taken_cnt != issued_cnt);
    if (rst_n && !offer) begin
      if (!feed_held && sample_feed.size() != 0) begin
        feed_cur  = sample_feed.pop_front();
        feed_gap  = feed_cur.gap;
        feed_held = 1'b1;
      end
      // a drain item waits for every outstanding result first
      if (feed_held && !(feed_cur.drain && resampled_q.size() != 0)) begin
        if (feed_gap != 0) begin
          feed_gap--;
        end else begin
          offer     = 1'b1;
          feed_held = 1'b0;
          issued_cnt++;
          in_mode   <= feed_cur.md;
          in_sample <= feed_cur.smp;
        end
      end
    end
    in_valid <= offer;
  end

  // result receiver
  int unsigned rx_wait   = 0;
  int unsigned rx_seen   = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  logic        rx_calm   = 1'b0;

  always @(negedge clk) begin
    logic stall_now;
    if (rx_seen != results_taken) begin
      rx_seen = results_taken;
      if (rx_seen % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
    end
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else if (out_valid && rx_wait != 0) begin
      rx_wait--;
      stall_now = 1'b1;
    end else begin
      stall_now = 1'b0;
    end
    out_stall <= stall_now;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_idle();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input logic md, input logic signed [SAMPLE_W-1:0] smp,
                           input int gap, input logic drain);
    feed_item_t it;
    it.md    = md;
    it.smp   = smp;
    it.gap   = 3'(gap);
    it.drain = drain;
    sample_feed.push_back(it);
  endtask

  // all items taken, all results in, then let a trailing down run finish
  task automatic wait_block_idle();
    while (sample_feed.size() != 0 || feed_held || taken_cnt != issued_cnt ||
           resampled_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int          ph;
    int          n;
    int          f;
    int          sec;
    int          down_pct;
    logic        calm;
    logic [31:0] gain;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] m1;
    logic [31:0] m2;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes through a stable low-pass at full gain
    write_reg(REG_RATE_FACTOR, 32'd4);
    write_reg(REG_OUTPUT_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_S1_A1, 32'h4000_0000);
    write_reg(REG_S1_A2, 32'hF000_0000);
    write_reg(REG_S2_A1, 32'h2000_0000);
    write_reg(REG_S2_A2, 32'hF800_0000);
    cfg_idle();
    push_item(MODE_UP, SAMPLE_MAX, $urandom_range(0, 5), 1'b0);
    push_item(MODE_UP, SAMPLE_MIN, $urandom_range(0, 5), 1'b0);
    push_item(MODE_DOWN, SAMPLE_MAX, $urandom_range(0, 5), 1'b0);
    push_item(MODE_DOWN, SAMPLE_MIN, $urandom_range(0, 5), 1'b0);
    push_item(MODE_DOWN, 24'sd1, $urandom_range(0, 5), 1'b0);
    push_item(MODE_DOWN, -24'sd1, $urandom_range(0, 5), 1'b0);
    wait_block_idle();

    // factor lowered while the decimator is part way through its count
    write_reg(REG_RATE_FACTOR, 32'd16);
    cfg_idle();
    repeat (6) push_item(MODE_DOWN, rand_sample(), $urandom_range(0, 5), 1'b0);
    wait_block_idle();
    write_reg(REG_RATE_FACTOR, 32'd3);
    cfg_idle();
    push_item(MODE_DOWN, rand_sample(), 0, 1'b0);
    wait_block_idle();

    // zero factor behaves as one, writes to spare indexes are dropped
    write_reg(REG_RATE_FACTOR, 32'd0);
    write_reg(IDX_SPARE_A, $urandom);
    write_reg(IDX_SPARE_B, $urandom);
    cfg_idle();
    push_item(MODE_UP, rand_sample(), $urandom_range(0, 5), 1'b0);
    push_item(MODE_DOWN, rand_sample(), $urandom_range(0, 5), 1'b0);
    wait_block_idle();

    // factors above the top clamp to it
    write_reg(REG_RATE_FACTOR, 32'd31);
    cfg_idle();
    push_item(MODE_UP, SAMPLE_MAX, 0, 1'b0);
    wait_block_idle();
    write_reg(REG_RATE_FACTOR, 32'd17);
    cfg_idle();
    push_item(MODE_UP, SAMPLE_MIN, 0, 1'b0);
    wait_block_idle();

    write_reg(REG_RATE_FACTOR, 32'd1);
    write_reg(REG_OUTPUT_GAIN, 32'd0);
    cfg_idle();
    push_item(MODE_UP, SAMPLE_MAX, 0, 1'b0);
    wait_block_idle();

    // extreme feedback drives the section state into saturation
    write_reg(REG_RATE_FACTOR, 32'd2);
    write_reg(REG_OUTPUT_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_S1_A1, 32'h8000_0000);
    write_reg(REG_S1_A2, 32'h7FFF_FFFF);
    write_reg(REG_S2_A1, 32'h7FFF_FFFF);
    write_reg(REG_S2_A2, 32'h8000_0000);
    cfg_idle();
    repeat (3) push_item(MODE_UP, SAMPLE_MAX, $urandom_range(0, 5), 1'b0);
    wait_block_idle();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       f = 0;
        1:       f = 31;
        2:       f = 16;
        3:       f = $urandom_range(5, 16);
        default: f = $urandom_range(1, 4);
      endcase
      write_reg(REG_RATE_FACTOR, 32'(f));
      case ($urandom_range(0, 3))
        0:       gain = $urandom;
        1:       gain = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: gain = $urandom_range(0, 32'h0400_0000);
      endcase
      write_reg(REG_OUTPUT_GAIN, gain);
      for (sec = 0; sec < 2; sec++) begin
        if (ph % 4 == 3) begin
          c1 = $urandom;
          c2 = $urandom;
        end else begin
          // poles inside the unit circle: |a2| < 1 and |a1| < 1 - a2
          m2 = $urandom_range(32'd858993459, 32'd107374182);
          m1 = $urandom_range(32'h4000_0000 + m2 - 32'h0400_0000, 0);
          c2 = -m2;
          c1 = $urandom_range(0, 1) ? m1 : -m1;
        end
        write_reg((sec == 0) ? REG_S1_A1 : REG_S2_A1, c1);
        write_reg((sec == 0) ? REG_S1_A2 : REG_S2_A2, c2);
      end
      cfg_idle();
      if (ph == 0 || ph == 4) hold_gen++;
      calm     = ($urandom_range(0, 2) == 0);
      down_pct = $urandom_range(10, 90);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        push_item(($urandom_range(1, 100) <= down_pct) ? MODE_DOWN : MODE_UP,
                  rand_sample(), calm ? 0 : $urandom_range(0, 5),
                  $urandom_range(0, 19) == 0);
      end
      wait_block_idle();
    end

    if (mismatches == 0 && resampled_q.size() == 0) begin
      $display("iir_oversampling_resampler: match");
    end else begin
      $display("iir_oversampling_resampler: mismatch");
    end
    $finish;
  end

endmodule
